// ===== hw/rtl/ogn2d_pkg.sv =====
// shared types, constants and arithmetic helpers for the octave gradient noise block
`default_nettype none

package ogn2d_pkg;

  // hash mixing multipliers
  localparam logic [31:0] MIX_A = 32'd3284157443;
  localparam logic [31:0] MIX_B = 32'd1911520717;
  localparam logic [31:0] MIX_C = 32'd2048419325;

  // width of one octave's noise sample (signed)
  localparam int NOISE_W = 18;
  // quotient bits produced by the normalizing divider
  localparam int QUO_W = 17;
  // register stages inside one octave unit
  localparam int OCT_STAGES = 11;

  // configuration register indexes
  localparam logic [1:0] REG_OCTAVE_COUNT = 2'd0;
  localparam logic [1:0] REG_PERSISTENCE  = 2'd1;

  typedef logic signed [NOISE_W-1:0] noise_t;

  function automatic logic [31:0] rot16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  // a0 + floor((a1 - a0) * s / 2^16)
  function automatic noise_t blend(input noise_t a0, input noise_t a1, input logic [16:0] s);
    logic signed [18:0] d;
    logic signed [36:0] pr;
    logic signed [20:0] sh;
    begin
      d  = 19'(a1) - 19'(a0);
      pr = 37'(d) * 37'($signed({1'b0, s}));
      sh = pr[36:16];
      return NOISE_W'(21'(a0) + sh);
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ogn2d_octave.sv =====
// one octave of 2d gradient noise: cell hash, gradient, dot products, smoothstep blend
`default_nettype none

module ogn2d_octave #(
  parameter int OCTAVE     = 0,
  parameter int FRAC_BITS  = 16,
  parameter int ANGLE_BITS = 10
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [31:0]  x_coord,
  input  wire logic signed [31:0]  y_coord,
  output ogn2d_pkg::noise_t        noise
);

  localparam int XW = 80;
  localparam logic [15:0] PMASK = 16'(16'hFFFF << (16 - ANGLE_BITS));

  // scaled coordinates
  logic signed [XW-1:0] xs, ys;
  logic [15:0] fxq, fyq;
  assign xs = XW'(x_coord) <<< OCTAVE;
  assign ys = XW'(y_coord) <<< OCTAVE;

  if (FRAC_BITS >= 16) begin : g_frac_shr
    assign fxq = xs[FRAC_BITS-1 -: 16];
    assign fyq = ys[FRAC_BITS-1 -: 16];
  end else begin : g_frac_shl
    assign fxq = {xs[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
    assign fyq = {ys[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
  end

  // stage registers
  logic [31:0] cx1 [2];
  logic [31:0] cy1 [2];
  logic [31:0] ha2 [2];
  logic [31:0] cy2 [2];
  logic [15:0] w2x2, w2y2;
  logic [31:0] ha3 [2];
  logic [31:0] b3  [4];
  logic [15:0] p4  [4];
  logic [15:0] u5 [8], u2_5 [8];
  logic        neg5 [8];
  logic [15:0] u6 [8], u2_6 [8];
  logic [14:0] inner6 [8];
  logic        neg6 [8];
  logic [15:0] u7 [8], mid7 [8];
  logic        neg7 [8];
  logic signed [15:0] g8 [8];
  ogn2d_pkg::noise_t dot9 [4];
  ogn2d_pkg::noise_t top10, bot10;
  logic [15:0] fx_s [1:8];
  logic [15:0] fy_s [1:8];
  logic [16:0] sx_s [3:9];
  logic [16:0] sy_s [3:10];

  // combinational helpers
  logic [31:0] sqx, sqy;
  logic [17:0] kx, ky;
  logic [33:0] spx, spy;
  logic [31:0] af4 [4];
  logic [14:0] v5c [8];
  logic [15:0] u5c [8];
  logic [31:0] sq5c [8];
  logic        neg5c [8];
  logic [27:0] t6c [8];
  logic [30:0] m7c [8];
  logic [31:0] p8c [8];
  logic [14:0] s8c [8];
  logic signed [16:0] dxc [4], dyc [4];
  logic signed [33:0] dsc [4];

  always_comb begin
    sqx = 32'(fx_s[1]) * 32'(fx_s[1]);
    sqy = 32'(fy_s[1]) * 32'(fy_s[1]);
    kx  = 18'd196608 - {1'b0, fx_s[2], 1'b0};
    ky  = 18'd196608 - {1'b0, fy_s[2], 1'b0};
    spx = 34'(w2x2) * 34'(kx);
    spy = 34'(w2y2) * 34'(ky);
    for (int c = 0; c < 4; c++) begin
      af4[c] = (ha3[c & 1] ^ ogn2d_pkg::rot16(b3[c])) * ogn2d_pkg::MIX_C;
      dxc[c] = $signed({c[0], fx_s[8]});
      dyc[c] = $signed({c[1], fy_s[8]});
      dsc[c] = 34'(dxc[c]) * 34'(g8[2*c]) + 34'(dyc[c]) * 34'(g8[2*c+1]);
    end
    for (int k = 0; k < 8; k++) begin
      v5c[k]   = (p4[k>>1][14] ^ k[0]) ? 15'd16384 - {1'b0, p4[k>>1][13:0]}
                                       : {1'b0, p4[k>>1][13:0]};
      neg5c[k] = k[0] ? (p4[k>>1][15] ^ p4[k>>1][14]) : p4[k>>1][15];
      u5c[k]   = {v5c[k], 1'b0};
      sq5c[k]  = 32'(u5c[k]) * 32'(u5c[k]);
      t6c[k]   = 28'(u2_5[k]) * 28'd2463;
      m7c[k]   = 31'(u2_6[k]) * 31'(inner6[k]);
      p8c[k]   = 32'(u7[k]) * 32'(mid7[k]);
      s8c[k]   = (p8c[k][31:15] > 17'd32767) ? 15'h7FFF : p8c[k][29:15];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // cell corners and fractions
      cx1[0]  <= xs[FRAC_BITS+31:FRAC_BITS];
      cx1[1]  <= xs[FRAC_BITS+31:FRAC_BITS] + 32'd1;
      cy1[0]  <= ys[FRAC_BITS+31:FRAC_BITS];
      cy1[1]  <= ys[FRAC_BITS+31:FRAC_BITS] + 32'd1;
      fx_s[1] <= fxq;
      fy_s[1] <= fyq;
      for (int st = 2; st <= 8; st++) begin
        fx_s[st] <= fx_s[st-1];
        fy_s[st] <= fy_s[st-1];
      end
      // hash round one, smoothstep square
      for (int i = 0; i < 2; i++) begin
        ha2[i] <= cx1[i] * ogn2d_pkg::MIX_A;
        cy2[i] <= cy1[i];
        ha3[i] <= ha2[i];
      end
      w2x2 <= sqx[31:16];
      w2y2 <= sqy[31:16];
      // hash rounds two and three, corner dot products, smoothstep cubic
      for (int c = 0; c < 4; c++) begin
        b3[c]   <= (cy2[c >> 1] ^ ogn2d_pkg::rot16(ha2[c & 1])) * ogn2d_pkg::MIX_B;
        p4[c]   <= af4[c][31:16] & PMASK;
        dot9[c] <= dsc[c][33:16];
      end
      sx_s[3] <= spx[32:16];
      sy_s[3] <= spy[32:16];
      for (int st = 4; st <= 9; st++) sx_s[st] <= sx_s[st-1];
      for (int st = 4; st <= 10; st++) sy_s[st] <= sy_s[st-1];
      // quarter-wave sine polynomial, eight evaluations per octave
      for (int k = 0; k < 8; k++) begin
        u5[k]     <= u5c[k];
        u2_5[k]   <= sq5c[k][30:15];
        neg5[k]   <= neg5c[k];
        u6[k]     <= u5[k];
        u2_6[k]   <= u2_5[k];
        neg6[k]   <= neg5[k];
        inner6[k] <= 15'd21167 - 15'(t6c[k][27:15]);
        u7[k]     <= u6[k];
        neg7[k]   <= neg6[k];
        mid7[k]   <= 16'd51472 - m7c[k][30:15];
        g8[k]     <= neg7[k] ? -$signed({1'b0, s8c[k]}) : $signed({1'b0, s8c[k]});
      end
      // blend in x, then y
      top10 <= ogn2d_pkg::blend(dot9[0], dot9[1], sx_s[9]);
      bot10 <= ogn2d_pkg::blend(dot9[2], dot9[3], sx_s[9]);
      noise <= ogn2d_pkg::blend(top10, bot10, sy_s[10]);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/octave_gradient_noise_2d_top.sv =====
// top level of the fractal 2d gradient noise pipeline
// usage:
//   sample channel: x_coord / y_coord (signed fixed point) with sample_valid;
//   a request is taken on a rising edge with sample_valid high and sample_stall low
//   result channel: noise_value (signed q1.15, saturated) with result_valid;
//   a request leaves on a rising edge with result_valid high and result_stall low
//   config channel: cfg_index / cfg_data with cfg_valid, always ready;
//   index 0 octave count (clamped to 1..MAX_OCTAVES), index 1 persistence (q1.15)
//   write config only while no request is in flight
// timing:
//   one request per cycle sustained while result_stall stays low
//   stages: input register, 11 octave stages (all octaves side by side),
//   one weighted-sum stage per octave, 18 divider stages (a setup stage, then
//   one quotient bit each), and the output register
// reset: rst clears all valid bits, octave count goes to 1, persistence to 0.5
// stall: the whole pipeline freezes while the output register holds a
//   request and result_stall is high; empty slots travel along otherwise
`default_nettype none

module octave_gradient_noise_2d_top #(
  parameter int MAX_OCTAVES = 8,
  parameter int ANGLE_BITS  = 10,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               sample_valid,
  output logic                    sample_stall,
  input  wire logic signed [31:0] x_coord,
  input  wire logic signed [31:0] y_coord,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic signed [15:0]      noise_value,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  localparam int NW     = ogn2d_pkg::NOISE_W;
  localparam int QW     = ogn2d_pkg::QUO_W;
  // amplitude of octave k stays below 2^(16+k)
  localparam int AMP_W  = 15 + MAX_OCTAVES;
  localparam int SUM_W  = AMP_W + 5;
  localparam int PROD_W = NW + AMP_W + 1;
  localparam int TOT_W  = PROD_W + 5;
  localparam int DW     = TOT_W + 1;
  // valid pipe positions
  localparam int V_ACC  = 1 + ogn2d_pkg::OCT_STAGES;
  localparam int V_DIV  = V_ACC + MAX_OCTAVES;
  localparam int LAT    = V_DIV + QW + 2;
  localparam logic [4:0] MAXO = 5'(MAX_OCTAVES);

  // config registers
  logic [3:0]  octave_count;
  logic [15:0] persistence;
  logic [4:0]  n_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= 4'd1;
      persistence  <= 16'd16384;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ogn2d_pkg::REG_OCTAVE_COUNT: octave_count <= cfg_data[3:0];
        ogn2d_pkg::REG_PERSISTENCE:  persistence  <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero means one octave, anything above the build limit is capped
  always_comb begin
    priority if (octave_count == 4'd0) n_eff = 5'd1;
    else if (5'({1'b0, octave_count}) > MAXO) n_eff = MAXO;
    else n_eff = 5'({1'b0, octave_count});
  end

  // pipeline advance and valid pipe
  logic en;
  logic vld [LAT];

  assign en           = !(vld[LAT-1] && result_stall);
  assign sample_stall = !en;
  assign result_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= sample_valid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // input register
  logic signed [31:0] x_r, y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_coord;
      y_r <= y_coord;
    end
  end

  // all octaves evaluated side by side
  ogn2d_pkg::noise_t oct_noise [MAX_OCTAVES];

  for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_oct
    ogn2d_octave #(
      .OCTAVE    (o),
      .FRAC_BITS (FRAC_BITS),
      .ANGLE_BITS(ANGLE_BITS)
    ) u_oct (
      .clk    (clk),
      .en     (en),
      .x_coord(x_r),
      .y_coord(y_r),
      .noise  (oct_noise[o])
    );
  end

  // weighted sum, one octave per stage, amplitude carried along
  logic signed [TOT_W-1:0] acc_r [MAX_OCTAVES];
  logic [SUM_W-1:0]        sum_r [MAX_OCTAVES];
  logic [AMP_W-1:0]        amp_r [MAX_OCTAVES];
  ogn2d_pkg::noise_t       nz_r  [MAX_OCTAVES][MAX_OCTAVES];

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_acc
    logic signed [TOT_W-1:0]  acc_in;
    logic [SUM_W-1:0]         sum_in;
    logic [AMP_W-1:0]         amp_in;
    ogn2d_pkg::noise_t        nz_in [MAX_OCTAVES];
    logic signed [PROD_W-1:0] term;
    logic [AMP_W+15:0]        ap;
    logic                     act;

    always_comb begin
      if (k == 0) begin
        acc_in = '0;
        sum_in = '0;
        amp_in = AMP_W'(32768);
        for (int j = 0; j < MAX_OCTAVES; j++) nz_in[j] = oct_noise[j];
      end else begin
        acc_in = acc_r[(k == 0) ? 0 : k-1];
        sum_in = sum_r[(k == 0) ? 0 : k-1];
        amp_in = amp_r[(k == 0) ? 0 : k-1];
        for (int j = 0; j < MAX_OCTAVES; j++) nz_in[j] = nz_r[(k == 0) ? 0 : k-1][j];
      end
      act  = 5'(k) < n_eff;
      term = PROD_W'(nz_in[k]) * PROD_W'($signed({1'b0, amp_in}));
      ap   = (AMP_W+16)'(amp_in) * (AMP_W+16)'(persistence);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[k] <= act ? acc_in + TOT_W'(term) : acc_in;
        sum_r[k] <= act ? sum_in + SUM_W'(amp_in) : sum_in;
        amp_r[k] <= ap[AMP_W+14:15];
        for (int j = 0; j < MAX_OCTAVES; j++) nz_r[k][j] <= nz_in[j];
      end
    end
  end

  // normalizing divide: magnitude restoring division, one quotient bit per stage
  logic [DW-1:0]    rem_r [QW+1];
  logic [SUM_W-1:0] dv_r  [QW+1];
  logic [QW-1:0]    q_r   [QW+1];
  logic             neg_r [QW+1];
  logic             ovf_r [QW+1];

  logic signed [TOT_W-1:0] tot;
  logic [TOT_W-1:0]        mag;

  assign tot = acc_r[MAX_OCTAVES-1];
  assign mag = tot[TOT_W-1] ? TOT_W'(-tot) : TOT_W'(tot);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DW'(mag);
      dv_r[0]  <= sum_r[MAX_OCTAVES-1];
      q_r[0]   <= '0;
      neg_r[0] <= tot[TOT_W-1];
      // quotient beyond the bits kept saturates anyway
      ovf_r[0] <= DW'(mag) >= (DW'(sum_r[MAX_OCTAVES-1]) << QW);
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_div
    localparam int B = QW - j;
    logic [DW-1:0] sd;
    logic          ge;

    assign sd = DW'(dv_r[j-1]) << B;
    assign ge = rem_r[j-1] >= sd;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? rem_r[j-1] - sd : rem_r[j-1];
        q_r[j]   <= ge ? (q_r[j-1] | (QW'(1) << B)) : q_r[j-1];
        dv_r[j]  <= dv_r[j-1];
        neg_r[j] <= neg_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
      end
    end
  end

  // sign and saturation into the output register
  logic [QW-1:0] qf;
  assign qf = q_r[QW];

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[QW]) begin
        noise_value <= (ovf_r[QW] || qf > QW'(32768)) ? 16'sh8000 : 16'(-qf);
      end else begin
        noise_value <= (ovf_r[QW] || qf > QW'(32767)) ? 16'sh7FFF : $signed(qf[15:0]);
      end
    end
  end

`ifndef SYNTHESIS
  // the divisor never reaches the divider as zero
  a_sum_nonzero: assert property (@(posedge clk) disable iff (rst)
    vld[V_DIV-1] |-> sum_r[MAX_OCTAVES-1] != '0)
    else $error("amplitude sum is zero at the divider");

  // a request one stage from the end always lands in the output register
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (vld[LAT-2] && !sample_stall) |=> result_valid)
    else $error("request lost before the output register");

  // the pipeline only freezes on a held output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (result_valid && result_stall))
    else $error("input stalled without a held result");
`endif

endmodule

`default_nettype wire

// ===== test/octave_gradient_noise_2d_top_tb.sv =====
// self-checking testbench for the octave gradient noise top level
`timescale 1ns / 1ps
`default_nettype none

module octave_gradient_noise_2d_top_tb;

  localparam int MAX_OCT = 8;
  localparam int ANG_BITS = 10;
  localparam int FRAC = 16;
  localparam int LATENCY = 31 + MAX_OCT;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [31:0] x_coord = '0;
  logic signed [31:0] y_coord = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [15:0] noise_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // predictor copy of the configuration registers
  logic [3:0] octaves_reg = 4'd1;
  logic [15:0] persist_reg = 16'd16384;

  sample_t pending_samples[$];
  logic signed [15:0] expected_noise[$];
  int errors = 0;
  int checked = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit hold_sender = 1'b0;
  bit stim_done = 1'b0;

  octave_gradient_noise_2d_top i_dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .x_coord(x_coord), .y_coord(y_coord),
    .result_valid(result_valid), .result_stall(result_stall),
    .noise_value(noise_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // floor division by 2^s for signed 64-bit values
  function automatic longint fshr(input longint v, input int s);
    return v >>> s;
  endfunction

  // polynomial quarter-wave sine, Q15
  function automatic longint qsin(input longint unsigned v);
    longint unsigned u, u2, inner, mid, s;
    u = v << 1;
    u2 = (u * u) >> 15;
    inner = 21167 - (2463 * u2) / 32768;
    mid = 51472 - (u2 * inner) / 32768;
    s = (u * mid) / 32768;
    if (s > 32767) s = 32767;
    return longint'(s);
  endfunction

  function automatic longint psin(input logic [15:0] p);
    logic [13:0] t;
    t = p[13:0];
    case (p[15:14])
      2'd0: return qsin(t);
      2'd1: return qsin(16384 - t);
      2'd2: return -qsin(t);
      default: return -qsin(16384 - t);
    endcase
  endfunction

  // hashed gradient at one cell corner dotted with the offset
  function automatic longint grad_dot(input logic [31:0] cx, input logic [31:0] cy,
                                      input longint dx, input longint dy);
    logic [31:0] a, b;
    logic [15:0] p;
    longint gx, gy;
    a = cx * ogn2d_pkg::MIX_A;
    b = cy ^ {a[15:0], a[31:16]};
    b = b * ogn2d_pkg::MIX_B;
    a = a ^ {b[15:0], b[31:16]};
    a = a * ogn2d_pkg::MIX_C;
    p = 16'((a >> (32 - ANG_BITS)) << (16 - ANG_BITS));
    gx = psin(p);
    gy = psin(p + 16'd16384);
    return fshr(dx * gx + dy * gy, 16);
  endfunction

  function automatic longint smoothstep(input longint w);
    longint w2;
    w2 = fshr(w * w, 16);
    return fshr(w2 * (3 * 65536 - 2 * w), 16);
  endfunction

  function automatic longint lerp(input longint a0, input longint a1, input longint s);
    return a0 + fshr((a1 - a0) * s, 16);
  endfunction

  function automatic longint octave_noise(input longint xs, input longint ys);
    longint fx, fy, sx, sy, top, bot;
    logic [31:0] x0, y0;
    x0 = 32'(fshr(xs, FRAC));
    y0 = 32'(fshr(ys, FRAC));
    fx = xs & ((64'd1 << FRAC) - 1);
    fy = ys & ((64'd1 << FRAC) - 1);
    sx = smoothstep(fx);
    sy = smoothstep(fy);
    top = lerp(grad_dot(x0, y0, fx, fy), grad_dot(x0 + 1, y0, fx - 65536, fy), sx);
    bot = lerp(grad_dot(x0, y0 + 1, fx, fy - 65536),
               grad_dot(x0 + 1, y0 + 1, fx - 65536, fy - 65536), sx);
    return lerp(top, bot, sy);
  endfunction

  function automatic logic signed [15:0] fractal_noise(input sample_t s);
    int n;
    longint total, r;
    longint unsigned amp, amp_sum;
    n = octaves_reg;
    if (n < 1) n = 1;
    if (n > MAX_OCT) n = MAX_OCT;
    amp = 32768;
    amp_sum = 0;
    total = 0;
    for (int i = 0; i < n; i++) begin
      total += octave_noise(longint'(s.x) <<< i, longint'(s.y) <<< i) * longint'(amp);
      amp_sum += amp;
      amp = (amp * persist_reg) >> 15;
    end
    r = total / longint'(amp_sum);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: pops queued samples, predicts each one as the request is accepted
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && !sample_stall) begin
        expected_noise.push_back(fractal_noise({x_coord, y_coord}));
        void'(pending_samples.pop_front());
      end
      if (sample_valid && sample_stall) begin
        // payload holds while stalled
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        sample_valid <= 1'b0;
      end else if (!hold_sender && pending_samples.size() > 0 &&
                   !(sample_valid && !sample_stall && pending_samples.size() == 1)) begin
        // take the head, or the next one if the head just went through
        if (sample_valid && !sample_stall) begin
          x_coord <= pending_samples[0].x;
          y_coord <= pending_samples[0].y;
        end else begin
          x_coord <= pending_samples[0].x;
          y_coord <= pending_samples[0].y;
        end
        sample_valid <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // monitor: compares each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_noise.size() == 0) begin
          $error("noise_value: unexpected result %0d", noise_value);
          errors++;
        end else begin
          if (noise_value !== expected_noise[0]) begin
            $error("noise_value mismatch: expected %0d actual %0d",
                   expected_noise[0], noise_value);
            errors++;
          end
          void'(expected_noise.pop_front());
          checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
        stall_left <= pick_gap();
      end
    end
  end

  // queue a sample for the driver to send
  task automatic push_sample(input logic [31:0] x, input logic [31:0] y);
    pending_samples.push_back({x, y});
  endtask

  task automatic wait_drained();
    while (pending_samples.size() > 0 || sample_valid || expected_noise.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // config write, only ever issued with the pipeline empty
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == ogn2d_pkg::REG_OCTAVE_COUNT) octaves_reg = val[3:0];
    else if (idx == ogn2d_pkg::REG_PERSISTENCE) persist_reg = val;
    @(posedge clk);
  endtask

  // random coordinate: mostly moderate, some full range
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
  endfunction

  // one phase of random samples under the given configuration
  task automatic run_phase(input logic [3:0] oct, input logic [15:0] pers, input int cnt);
    write_reg(ogn2d_pkg::REG_OCTAVE_COUNT, oct);
    write_reg(ogn2d_pkg::REG_PERSISTENCE, pers);
    for (int i = 0; i < cnt; i++) push_sample(rand_coord(), rand_coord());
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: reset configuration, field extremes and cell edges
    push_sample(32'h0, 32'h0);
    push_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_sample(32'h8000_0000, 32'h8000_0000);
    push_sample(32'h7FFF_FFFF, 32'h8000_0000);
    push_sample(32'hFFFF_FFFF, 32'h0000_FFFF);
    push_sample(32'h0001_0000, 32'hFFFF_0000);
    push_sample(32'h0000_8000, 32'h0000_8000);
    push_sample(32'h5555_5555, 32'hAAAA_AAAA);
    wait_drained();
    // zero octave count acts as one octave
    write_reg(ogn2d_pkg::REG_OCTAVE_COUNT, 4'd0);
    push_sample(32'h0003_4000, 32'hFFFE_2000);
    push_sample(32'h7FFF_FFFF, 32'h8000_0000);
    wait_drained();
    // octave count above the maximum, full persistence
    write_reg(ogn2d_pkg::REG_OCTAVE_COUNT, 4'd15);
    write_reg(ogn2d_pkg::REG_PERSISTENCE, 16'hFFFF);
    push_sample(32'h8000_0000, 32'h7FFF_FFFF);
    push_sample(32'h1234_5678, 32'h9ABC_DEF0);
    wait_drained();
    // zero persistence keeps only the first octave
    write_reg(ogn2d_pkg::REG_PERSISTENCE, 16'd0);
    push_sample(32'h0003_4000, 32'hFFFE_2000);
    push_sample(32'hFFFF_FFFF, 32'h0000_0001);
    wait_drained();
    // unused register index is ignored by the block
    write_reg(2'd3, 16'hFFFF);
    write_reg(2'd2, 16'h0000);
    push_sample(32'h0003_4000, 32'hFFFE_2000);
    wait_drained();
    // random phases across the configuration space
    run_phase(4'd1, 16'd16384, 200);
    run_phase(4'd8, 16'd16384, 300);
    run_phase(4'd8, 16'hFFFF, 200);
    run_phase(4'd4, 16'd0, 150);
    run_phase(4'd0, 16'd32768, 100);
    // sender holds until the pipeline drains, then resumes
    write_reg(ogn2d_pkg::REG_OCTAVE_COUNT, 4'($urandom_range(1, 8)));
    write_reg(ogn2d_pkg::REG_PERSISTENCE, 16'($urandom));
    for (int i = 0; i < 50; i++) push_sample(rand_coord(), rand_coord());
    repeat (60) @(posedge clk);
    hold_sender = 1'b1;
    while (expected_noise.size() > 0) @(posedge clk);
    hold_sender = 1'b0;
    for (int i = 0; i < 50; i++) push_sample(rand_coord(), rand_coord());
    wait_drained();
    for (int p = 0; p < 8; p++)
      run_phase(4'($urandom_range(0, 15)), 16'($urandom), 100);
    $display("checked %0d noise results across octave counts 0..15 and persistence extremes",
             checked);
    $display("errors: %0d", errors);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
